// ===== hdl/dvtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvtu_pkg
// Shared widths, command codes and control types for the routing table block.
// ----------------------------------------------------------------------------
package dvtu_pkg;

   localparam int IDX_W    = 3;
   localparam int ROUTERS  = 1 << IDX_W;
   localparam int COST_W   = 16;
   localparam int PORT_W   = 16;
   localparam int CMD_W    = 2;

   localparam logic [COST_W-1:0] INF_COST = {COST_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FAIL   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

endpackage

// ===== hdl/dvtu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvtu_ctrl
// Sequencer: takes an item, runs the table update, hands over the result.
// ----------------------------------------------------------------------------
module dvtu_ctrl
   import dvtu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctl_cmd_type ctl_cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign ctl_cmd.capture = req_valid && req_ready;
   assign ctl_cmd.commit  = commit;
   assign rsp_valid       = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/dvtu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvtu_datapath
// Route tables, relaxation adder and compare, result register.
// ----------------------------------------------------------------------------
module dvtu_datapath
   import dvtu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       ctl_cmd,
   input  logic              csr_write_en,
   input  logic [IDX_W-1:0]  csr_write_data,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [IDX_W-1:0]  req_router,
   input  logic [IDX_W-1:0]  req_sender,
   input  logic [COST_W-1:0] req_cost,
   input  logic [PORT_W-1:0] req_port,
   input  logic              req_last,
   output logic [IDX_W-1:0]  rsp_dest,
   output logic [COST_W-1:0] rsp_route_cost,
   output logic [IDX_W-1:0]  rsp_next_hop,
   output logic              rsp_entry_changed,
   output logic              rsp_table_changed,
   output logic              rsp_done_res
);

   // tables
   logic [COST_W-1:0] act_cost_ff [ROUTERS];
   logic [IDX_W-1:0]  act_hop_ff  [ROUTERS];
   logic [PORT_W-1:0] act_port_ff [ROUTERS];
   logic [COST_W-1:0] ini_cost_ff [ROUTERS];
   logic [PORT_W-1:0] ini_port_ff [ROUTERS];
   logic [ROUTERS-1:0] ini_valid_ff;

   logic [IDX_W-1:0]  self_ff;
   logic [COST_W-1:0] sac_ff;
   logic              cs_ff;
   logic              in_adv_ff;

   // held item
   logic [CMD_W-1:0]  cmd_ff;
   logic [IDX_W-1:0]  r_ff;
   logic [IDX_W-1:0]  s_ff;
   logic [COST_W-1:0] c_ff;
   logic [PORT_W-1:0] p_ff;
   logic              last_ff;
   logic [COST_W-1:0] via_cost_ff;
   logic              via_vld_ff;

   // results
   logic [IDX_W-1:0]  dest_ff;
   logic [COST_W-1:0] rcost_ff, rcost_in;
   logic [IDX_W-1:0]  hop_ff, hop_in;
   logic              ent_ff, ent_in;
   logic              tab_ff, tab_in;
   logic              done_ff, done_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [COST_W-1:0] rd_cost;
   logic [COST_W-1:0] c_norm;
   logic              is_adv, start, revive, via_ok, orig_vld, relax, rs_same;
   logic [COST_W-1:0] orig;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] sac_cur;
   logic              cs_cur;
   logic              vld_after;
   logic [COST_W-1:0] cost_after;

   assign rd_addr = ctl_cmd.capture ? req_sender : r_ff;
   assign rd_cost = act_cost_ff[rd_addr];
   assign c_norm  = (req_cost >= INF_COST) ? INF_COST : req_cost;

   always_comb begin
      is_adv   = (cmd_ff == CMD_ADVERT);
      rs_same  = (r_ff == s_ff);
      start    = is_adv && !in_adv_ff;
      revive   = start && !ini_valid_ff[s_ff];
      via_ok   = (via_vld_ff || start) && (via_cost_ff < INF_COST);
      orig_vld = ini_valid_ff[r_ff] || (start && rs_same);
      orig     = orig_vld ? rd_cost : INF_COST;
      sum      = {1'b0, via_cost_ff} + {1'b0, c_ff};
      relax    = is_adv && (r_ff != self_ff) && via_ok && (c_ff < INF_COST)
                 && (sum < {1'b0, INF_COST})
                 && ((orig >= INF_COST) || (sum < {1'b0, orig}));
      if (is_adv && (r_ff == self_ff)) sac_cur = c_ff;
      else if (start)                  sac_cur = INF_COST;
      else                             sac_cur = sac_ff;
      cs_cur   = (start ? 1'b0 : cs_ff) || revive || relax;
   end

   always_comb begin
      vld_after  = ini_valid_ff[r_ff];
      cost_after = rd_cost;
      hop_in     = act_hop_ff[r_ff];
      ent_in     = 1'b0;
      tab_in     = 1'b0;
      done_in    = 1'b0;
      unique case (cmd_ff)
         CMD_LOAD: begin
            vld_after  = 1'b1;
            cost_after = c_ff;
            hop_in     = r_ff;
         end
         CMD_ADVERT: begin
            vld_after = ini_valid_ff[r_ff] || (revive && rs_same);
            priority if (last_ff && rs_same) cost_after = sac_cur;
            else if (relax)                  cost_after = sum[COST_W-1:0];
            else                             cost_after = rd_cost;
            if (relax) hop_in = s_ff;
            ent_in  = relax;
            tab_in  = last_ff && cs_cur;
            done_in = last_ff;
         end
         CMD_FAIL: begin
            vld_after  = ini_valid_ff[r_ff] && !(ini_cost_ff[r_ff] < INF_COST);
            cost_after = ini_cost_ff[r_ff];
            hop_in     = (ini_cost_ff[r_ff] >= INF_COST) ? '0 : r_ff;
            done_in    = 1'b1;
         end
         CMD_NONE: begin
            vld_after  = ini_valid_ff[r_ff];
         end
         default: vld_after = ini_valid_ff[r_ff];
      endcase
      rcost_in = vld_after ? cost_after : INF_COST;
   end

   // capture item and sender's cost
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff      <= req_cmd;
         r_ff        <= req_router;
         s_ff        <= req_sender;
         c_ff        <= c_norm;
         p_ff        <= req_port;
         last_ff     <= req_last;
         via_cost_ff <= rd_cost;
         via_vld_ff  <= ini_valid_ff[req_sender];
      end
      if (ctl_cmd.commit) begin
         dest_ff  <= r_ff;
         rcost_ff <= rcost_in;
         hop_ff   <= hop_in;
         ent_ff   <= ent_in;
         tab_ff   <= tab_in;
         done_ff  <= done_in;
      end
   end

   // table update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROUTERS; i++) begin
            act_cost_ff[i] <= INF_COST;
            act_hop_ff[i]  <= '0;
            act_port_ff[i] <= '0;
            ini_cost_ff[i] <= INF_COST;
            ini_port_ff[i] <= '0;
         end
         ini_valid_ff <= '1;
         self_ff      <= '0;
         sac_ff       <= INF_COST;
         cs_ff        <= 1'b0;
         in_adv_ff    <= 1'b0;
      end else begin
         if (csr_write_en) self_ff <= csr_write_data;
         if (ctl_cmd.commit) begin
            unique case (cmd_ff)
               CMD_LOAD: begin
                  ini_cost_ff[r_ff]  <= c_ff;
                  ini_port_ff[r_ff]  <= p_ff;
                  ini_valid_ff[r_ff] <= 1'b1;
                  act_cost_ff[r_ff]  <= c_ff;
                  act_hop_ff[r_ff]   <= r_ff;
                  act_port_ff[r_ff]  <= p_ff;
               end
               CMD_ADVERT: begin
                  if (revive) ini_valid_ff[s_ff] <= 1'b1;
                  if (relax) begin
                     act_cost_ff[r_ff] <= sum[COST_W-1:0];
                     act_hop_ff[r_ff]  <= s_ff;
                     act_port_ff[r_ff] <= p_ff;
                  end
                  if (last_ff) act_cost_ff[s_ff] <= sac_cur;
                  in_adv_ff <= !last_ff;
                  cs_ff     <= last_ff ? 1'b0 : cs_cur;
                  sac_ff    <= last_ff ? INF_COST : sac_cur;
               end
               CMD_FAIL: begin
                  if (ini_cost_ff[r_ff] < INF_COST) ini_valid_ff[r_ff] <= 1'b0;
                  for (int i = 0; i < ROUTERS; i++) begin
                     act_cost_ff[i] <= ini_cost_ff[i];
                     act_hop_ff[i]  <= (ini_cost_ff[i] >= INF_COST) ? '0 : IDX_W'(i);
                     act_port_ff[i] <= ini_port_ff[i];
                  end
                  in_adv_ff <= 1'b0;
                  cs_ff     <= 1'b0;
                  sac_ff    <= INF_COST;
               end
               CMD_NONE: begin
                  cs_ff <= cs_ff;
               end
               default: cs_ff <= cs_ff;
            endcase
         end
      end
   end

   assign rsp_dest          = dest_ff;
   assign rsp_route_cost    = rcost_ff;
   assign rsp_next_hop      = hop_ff;
   assign rsp_entry_changed = ent_ff;
   assign rsp_table_changed = tab_ff;
   assign rsp_done_res      = done_ff;

endmodule

// ===== hdl/distance_vector_table_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Distance-vector routing table with Bellman-Ford relaxation per element.
// ----------------------------------------------------------------------------
// For each item, the transfer cycle reads the sender's active cost from the
// table; the update cycle then reads the destination's cost, does the add
// and compare, writes the tables back and loads the result register. The
// single read port on the active cost table is why the two reads are split.
// A new item is taken only when the sequencer is idle; its update cycle is
// held until the result register is free or being drained. A neighbour-failed
// command copies the whole initial table in that same update cycle.
// ----------------------------------------------------------------------------
module distance_vector_table_update
   import dvtu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [IDX_W-1:0]  csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [IDX_W-1:0]  req_router,
   input  logic [IDX_W-1:0]  req_sender,
   input  logic [COST_W-1:0] req_cost,
   input  logic [PORT_W-1:0] req_port,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_dest,
   output logic [COST_W-1:0] rsp_route_cost,
   output logic [IDX_W-1:0]  rsp_next_hop,
   output logic              rsp_entry_changed,
   output logic              rsp_table_changed,
   output logic              rsp_done_res
);

   ctl_cmd_type ctl_cmd;

   dvtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl_cmd   (ctl_cmd)
   );

   dvtu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl_cmd           (ctl_cmd),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_cmd           (req_cmd),
      .req_router        (req_router),
      .req_sender        (req_sender),
      .req_cost          (req_cost),
      .req_port          (req_port),
      .req_last          (req_last),
      .rsp_dest          (rsp_dest),
      .rsp_route_cost    (rsp_route_cost),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_entry_changed (rsp_entry_changed),
      .rsp_table_changed (rsp_table_changed),
      .rsp_done_res      (rsp_done_res)
   );

endmodule

// ===== tb/distance_vector_table_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_table_update_test
// Self-checking testbench for the distance-vector routing table block.
// ----------------------------------------------------------------------------
// A behavioural copy of the routing table predicts the result of every request
// transfer at the moment it is accepted. A checker pops those predictions in
// order and compares each response transfer field by field. Directed tests hit
// loads, relaxation corner cases, missing self entries, neighbour failure and
// revival and the unused command. Random traffic is mostly well-formed
// advertisements, mixed with loads, failures and broken sequences, run under
// three handshake pressure settings and several self_index values.
// ----------------------------------------------------------------------------
module distance_vector_table_update_test
   import dvtu_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [IDX_W-1:0]  dest;
      logic [COST_W-1:0] route_cost;
      logic [IDX_W-1:0]  next_hop;
      logic              entry_changed;
      logic              table_changed;
      logic              done_res;
   } route_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [IDX_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd = CMD_NONE;
   logic [IDX_W-1:0]  req_router = '0;
   logic [IDX_W-1:0]  req_sender = '0;
   logic [COST_W-1:0] req_cost = '0;
   logic [PORT_W-1:0] req_port = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [IDX_W-1:0]  rsp_dest;
   logic [COST_W-1:0] rsp_route_cost;
   logic [IDX_W-1:0]  rsp_next_hop;
   logic              rsp_entry_changed;
   logic              rsp_table_changed;
   logic              rsp_done_res;

   // predicted table state
   logic [COST_W-1:0] tbl_cost [ROUTERS];
   logic [IDX_W-1:0]  tbl_hop [ROUTERS];
   logic [COST_W-1:0] init_cost [ROUTERS];
   logic              init_valid [ROUTERS];
   logic [COST_W-1:0] adv_self_cost;
   logic              adv_change_seen;
   logic              adv_open;
   logic [IDX_W-1:0]  self_idx;

   route_report_type expected_reports[$];

   int unsigned send_idle_pct = 18;
   int unsigned rsp_stall_pct = 67;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned n_transfers = 0;
   int unsigned n_results = 0;
   int unsigned n_adverts = 0;
   int unsigned n_relaxed = 0;

   distance_vector_table_update dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_router        (req_router),
      .req_sender        (req_sender),
      .req_cost          (req_cost),
      .req_port          (req_port),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest          (rsp_dest),
      .rsp_route_cost    (rsp_route_cost),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_entry_changed (rsp_entry_changed),
      .rsp_table_changed (rsp_table_changed),
      .rsp_done_res      (rsp_done_res)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic note_failure(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [COST_W-1:0] visible_cost(logic [IDX_W-1:0] i);
      return init_valid[i] ? tbl_cost[i] : INF_COST;
   endfunction

   function automatic void clear_table_state();
      for (int i = 0; i < ROUTERS; i++) begin
         tbl_cost[i]   = INF_COST;
         tbl_hop[i]    = '0;
         init_cost[i]  = INF_COST;
         init_valid[i] = 1'b1;
      end
      adv_self_cost   = INF_COST;
      adv_change_seen = 1'b0;
      adv_open        = 1'b0;
      self_idx        = '0;
   endfunction

   function automatic route_report_type predict_route_report(
      logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] router, logic [IDX_W-1:0] sender,
      logic [COST_W-1:0] cost, logic last);
      route_report_type  rep;
      logic [COST_W-1:0] via;
      logic [COST_W-1:0] orig;
      logic [COST_W:0]   sum;
      rep = '0;
      case (cmd)
         CMD_LOAD: begin
            init_cost[router]  = cost;
            init_valid[router] = 1'b1;
            tbl_cost[router]   = cost;
            tbl_hop[router]    = router;
         end
         CMD_ADVERT: begin
            if (!adv_open) begin
               adv_open        = 1'b1;
               adv_change_seen = 1'b0;
               adv_self_cost   = INF_COST;
               if (!init_valid[sender]) begin
                  init_valid[sender] = 1'b1;
                  adv_change_seen    = 1'b1;
               end
            end
            if (router == self_idx) begin
               adv_self_cost = cost;
            end else begin
               via  = visible_cost(sender);
               orig = visible_cost(router);
               if (via != INF_COST && cost != INF_COST) begin
                  sum = {1'b0, via} + {1'b0, cost};
                  if (sum < INF_COST && (orig == INF_COST || sum < orig)) begin
                     tbl_cost[router]  = sum[COST_W-1:0];
                     tbl_hop[router]   = sender;
                     rep.entry_changed = 1'b1;
                     adv_change_seen   = 1'b1;
                     n_relaxed++;
                  end
               end
            end
            if (last) begin
               tbl_cost[sender]  = adv_self_cost;
               rep.table_changed = adv_change_seen;
               rep.done_res      = 1'b1;
               adv_open          = 1'b0;
               adv_change_seen   = 1'b0;
               adv_self_cost     = INF_COST;
               n_adverts++;
            end
         end
         CMD_FAIL: begin
            if (init_cost[router] != INF_COST) init_valid[router] = 1'b0;
            for (int i = 0; i < ROUTERS; i++) begin
               tbl_cost[i] = init_cost[i];
               tbl_hop[i]  = (init_cost[i] == INF_COST) ? '0 : IDX_W'(i);
            end
            adv_open        = 1'b0;
            adv_change_seen = 1'b0;
            adv_self_cost   = INF_COST;
            rep.done_res    = 1'b1;
         end
         default: ;
      endcase
      rep.dest       = router;
      rep.route_cost = visible_cost(router);
      rep.next_hop   = tbl_hop[router];
      return rep;
   endfunction

   function automatic logic [COST_W-1:0] pick_cost();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return COST_W'($urandom_range(15));
      if (roll < 75) return COST_W'($urandom_range(255, 16));
      if (roll < 85) return INF_COST;
      if (roll < 92) return COST_W'($urandom_range(65534, 65500));
      return COST_W'($urandom_range(65535));
   endfunction

   // Hold valid across back-to-back items; drop it only for an idle gap.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] router,
                            logic [IDX_W-1:0] sender, logic [COST_W-1:0] cost,
                            logic [PORT_W-1:0] port, logic last);
      route_report_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_router <= router;
      req_sender <= sender;
      req_cost   <= cost;
      req_port   <= port;
      req_last   <= last;
      do @(posedge clock); while (!req_ready);
      rep = predict_route_report(cmd, router, sender, cost, last);
      expected_reports.insert(expected_reports.size(), rep);
      n_transfers++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_self_index(logic [IDX_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      self_idx = value;
   endtask

   always @(posedge clock) begin : check_reports
      route_report_type got;
      route_report_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_dest, rsp_route_cost, rsp_next_hop, rsp_entry_changed,
                rsp_table_changed, rsp_done_res};
         n_results++;
         if (expected_reports.size() == 0) begin
            note_failure($sformatf("unexpected response for dest %0d", got.dest));
         end else begin
            want = expected_reports.pop_front();
            if (got.dest !== want.dest)
               note_failure($sformatf("dest %0d, expected %0d", got.dest, want.dest));
            if (got.route_cost !== want.route_cost)
               note_failure($sformatf("dest %0d route_cost %0d, expected %0d",
                                      want.dest, got.route_cost, want.route_cost));
            if (got.next_hop !== want.next_hop)
               note_failure($sformatf("dest %0d next_hop %0d, expected %0d",
                                      want.dest, got.next_hop, want.next_hop));
            if (got.entry_changed !== want.entry_changed)
               note_failure($sformatf("dest %0d entry_changed %b, expected %b",
                                      want.dest, got.entry_changed, want.entry_changed));
            if (got.table_changed !== want.table_changed)
               note_failure($sformatf("dest %0d table_changed %b, expected %b",
                                      want.dest, got.table_changed, want.table_changed));
            if (got.done_res !== want.done_res)
               note_failure($sformatf("dest %0d done_res %b, expected %b",
                                      want.dest, got.done_res, want.done_res));
         end
      end
   end

   task automatic test_load_entries();
      send_item(CMD_LOAD, 3'd1, 3'd0, 16'd4, 16'h0000, 1'b0);
      send_item(CMD_LOAD, 3'd2, 3'd7, INF_COST, 16'hFFFF, 1'b1);
      send_item(CMD_LOAD, 3'd3, 3'd5, 16'd0, 16'hA5A5, 1'b0);
      send_item(CMD_LOAD, 3'd7, 3'd2, 16'd20, 16'h5A5A, 1'b0);
   endtask

   // sender 1 sits at cost 4
   task automatic test_route_relaxation();
      send_item(CMD_ADVERT, 3'd0, 3'd1, 16'd4, 16'h1111, 1'b0);
      send_item(CMD_ADVERT, 3'd2, 3'd1, 16'd3, 16'h1111, 1'b0);
      send_item(CMD_ADVERT, 3'd3, 3'd1, 16'd10, 16'h1111, 1'b0);
      send_item(CMD_ADVERT, 3'd5, 3'd1, 16'd65531, 16'h1111, 1'b0);
      send_item(CMD_ADVERT, 3'd6, 3'd1, INF_COST, 16'h1111, 1'b0);
      send_item(CMD_ADVERT, 3'd7, 3'd1, 16'd16, 16'h1111, 1'b1);
   endtask

   task automatic test_missing_self_entry();
      send_item(CMD_ADVERT, 3'd1, 3'd3, 16'd2, 16'h3333, 1'b0);
      send_item(CMD_ADVERT, 3'd2, 3'd3, 16'd1, 16'h3333, 1'b1);
   endtask

   task automatic test_neighbour_failure();
      send_item(CMD_FAIL, 3'd4, 3'd0, 16'd0, 16'h0000, 1'b0);
      send_item(CMD_ADVERT, 3'd1, 3'd7, 16'd1, 16'h7777, 1'b0);
      send_item(CMD_FAIL, 3'd7, 3'd3, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(CMD_ADVERT, 3'd0, 3'd7, 16'd9, 16'h7777, 1'b1);
   endtask

   task automatic test_unknown_command();
      send_item(CMD_NONE, 3'd2, 3'd5, 16'd1, 16'h0F0F, 1'b0);
      send_item(CMD_NONE, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   task automatic send_advertisement(logic [IDX_W-1:0] sender, bit complete,
                                     inout int unsigned sent);
      logic [IDX_W-1:0] dests[$];
      logic [PORT_W-1:0] port;
      port = PORT_W'($urandom_range(65535));
      for (int d = 0; d < ROUTERS; d++)
         if ($urandom_range(3) != 0) dests.insert(dests.size(), IDX_W'(d));
      if (dests.size() == 0)
         dests.insert(0, IDX_W'($urandom_range(ROUTERS - 1)));
      if (!complete) dests = dests[0:$urandom_range(dests.size() - 1)];
      foreach (dests[k]) begin
         send_item(CMD_ADVERT, dests[k], sender, pick_cost(), port,
                   complete && (k == dests.size() - 1));
         sent++;
      end
   endtask

   task automatic test_random_traffic(int unsigned items);
      int unsigned sent;
      int unsigned roll;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            send_advertisement(IDX_W'($urandom_range(ROUTERS - 1)), 1'b1, sent);
         end else if (roll < 80) begin
            send_item(CMD_LOAD, IDX_W'($urandom_range(ROUTERS - 1)),
                      IDX_W'($urandom_range(ROUTERS - 1)), pick_cost(),
                      PORT_W'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
         end else if (roll < 84) begin
            send_item(CMD_FAIL, IDX_W'($urandom_range(ROUTERS - 1)),
                      IDX_W'($urandom_range(ROUTERS - 1)), pick_cost(),
                      PORT_W'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
         end else if (roll < 89) begin
            send_item(CMD_NONE, IDX_W'($urandom_range(ROUTERS - 1)),
                      IDX_W'($urandom_range(ROUTERS - 1)), pick_cost(),
                      PORT_W'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
         end else if (roll < 95) begin
            send_advertisement(IDX_W'($urandom_range(ROUTERS - 1)), 1'b0, sent);
         end else begin
            send_item(CMD_ADVERT, IDX_W'($urandom_range(ROUTERS - 1)),
                      IDX_W'($urandom_range(ROUTERS - 1)), pick_cost(),
                      PORT_W'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      clear_table_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_self_index(3'd0);
      test_load_entries();
      test_route_relaxation();
      test_missing_self_entry();
      test_neighbour_failure();
      test_unknown_command();

      settle();
      write_self_index(3'd7);
      test_random_traffic(500);

      settle();
      send_idle_pct = 67;
      rsp_stall_pct = 18;
      write_self_index(3'd3);
      test_random_traffic(500);

      settle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_self_index(3'd0);
      test_random_traffic(500);

      settle();
      $display("covered %0d request transfers and %0d responses under self_index 0, 7 and 3",
               n_transfers, n_results);
      $display("%0d advertisements completed, %0d routes relaxed, three pressure settings",
               n_adverts, n_relaxed);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
